FILE: rtl/svc_layer_packet_filter_core_assert.svh
// Assertion macros used by the checker file.
`ifndef SVC_LAYER_PACKET_FILTER_CORE_ASSERT_SVH
`define SVC_LAYER_PACKET_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define SVCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define SVCF_ASSERT_NXT(lbl, clk, ante, cons, msg, rst_n) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SVCF_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/svcf_pkg.sv
package svcf_pkg;

    // Largest layer count honored; larger counts act as this.
    localparam int LAYER_MAX = 8;

    // Current layer, two's complement; -1 means no layer yet.
    typedef logic signed [3:0] layer_t;

    localparam layer_t LAYER_NONE = layer_t'(-1);
    localparam layer_t LAYER_ZERO = layer_t'(0);

    typedef enum logic [1:0] {
        REG_SPATIAL_COUNT   = 2'd0,
        REG_TEMPORAL_COUNT  = 2'd1,
        REG_TARGET_SPATIAL  = 2'd2,
        REG_TARGET_TEMPORAL = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [3:0] spatial_count;
        logic [3:0] temporal_count;
        logic [2:0] target_spatial;
        logic [2:0] target_temporal;
    } cfg_t;

    typedef struct packed {
        logic [2:0] spatial;
        logic [2:0] temporal;
        logic       key_frame;
        logic       end_of_frame;
    } pkt_t;

    typedef struct packed {
        logic   forward;
        logic   set_marker;
        layer_t new_spatial;
        layer_t new_temporal;
    } verdict_t;

    localparam logic [4:0] LAYER_MAX_W = 5'(LAYER_MAX);

    function automatic logic [4:0] clamp_count(input logic [3:0] cnt);
        logic [4:0] wide;
        wide = {1'b0, cnt};
        return (wide > LAYER_MAX_W) ? LAYER_MAX_W : wide;
    endfunction

endpackage

FILE: rtl/svcf_decide.sv
module svcf_decide
    import svcf_pkg::*;
(
    input  cfg_t     cfg,
    input  pkt_t     pkt,
    input  layer_t   cur_spatial,
    input  layer_t   cur_temporal,
    output verdict_t verdict
);

    layer_t tgt_s;
    layer_t tgt_t;
    layer_t ps;
    layer_t pt;
    layer_t s_mid;
    layer_t t_mid;
    layer_t t_fin;
    logic   too_high;
    logic   fwd;

    assign tgt_s = layer_t'({1'b0, cfg.target_spatial});
    assign tgt_t = layer_t'({1'b0, cfg.target_temporal});
    assign ps    = layer_t'({1'b0, pkt.spatial});
    assign pt    = layer_t'({1'b0, pkt.temporal});

    assign too_high = ({2'b00, pkt.spatial}  >= clamp_count(cfg.spatial_count)) ||
                      ({2'b00, pkt.temporal} >= clamp_count(cfg.temporal_count));

    // spatial step; a move restarts the temporal layer
    always_comb begin
        s_mid = cur_spatial;
        t_mid = cur_temporal;
        if (tgt_s > cur_spatial) begin
            if (pkt.key_frame) begin
                s_mid = tgt_s;
                t_mid = LAYER_ZERO;
            end
        end else if (tgt_s < cur_spatial) begin
            if (ps == tgt_s && pkt.end_of_frame) begin
                s_mid = tgt_s;
                t_mid = LAYER_ZERO;
            end
        end
    end

    // temporal step, judged against the layer before the spatial step
    always_comb begin
        t_fin = t_mid;
        if (tgt_t > cur_temporal) begin
            if (pt > cur_temporal) begin
                t_fin = pt;
            end
        end else if (tgt_t < cur_temporal) begin
            if (pt == tgt_t && pkt.end_of_frame) begin
                t_fin = pt;
            end
        end
    end

    assign fwd = !too_high && !(ps > s_mid) && !(pt > t_fin);

    assign verdict.forward      = fwd;
    assign verdict.set_marker   = fwd && (ps == s_mid) && pkt.end_of_frame;
    assign verdict.new_spatial  = s_mid;
    assign verdict.new_temporal = t_fin;

endmodule

FILE: rtl/svc_layer_packet_filter_core.sv
// Layer filter for scalable video packets.
// Input channel (s_*): one packet descriptor per beat - spatial layer,
// temporal layer, key-frame and end-of-frame flags.
// Result channel (m_*): one beat per input beat, in order - forward (keep or
// drop) and set_marker (force the RTP marker bit; low on a drop).
// Config channel (cfg_*): index 0 spatial count, 1 temporal count,
// 2 target spatial, 3 target temporal; always ready, write only while idle.
// Path: input register, then result register. Throughput: one beat per
// cycle while m_ready is high. The current-layer registers are read and
// updated in the same cycle an item moves from the input register to the
// result register, so the next item always sees the updated layers.
// Stall: with m_ready low the result holds; the input register still takes
// one more beat if it is empty, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): both stages empty, counts 1, targets 0,
// current layers -1 (no layer yet).
module svc_layer_packet_filter_core
    import svcf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_pkt_spatial,
    input  logic [2:0] s_pkt_temporal,
    input  logic       s_key_frame,
    input  logic       s_end_of_frame,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_forward,
    output logic       m_set_marker
);

    cfg_t     cfg_reg;
    logic     in_valid_reg;
    pkt_t     in_pkt_reg;
    logic     out_valid_reg;
    logic     out_forward_reg;
    logic     out_marker_reg;
    layer_t   cur_spatial_reg;
    layer_t   cur_temporal_reg;
    layer_t   cur_spatial_next;
    layer_t   cur_temporal_next;
    verdict_t verdict;
    logic     advance;

    svcf_decide u_decide (
        .cfg          (cfg_reg),
        .pkt          (in_pkt_reg),
        .cur_spatial  (cur_spatial_reg),
        .cur_temporal (cur_temporal_reg),
        .verdict      (verdict)
    );

    // input register moves on when the result register is free or drains
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // layers stick only for forwarded packets
    assign cur_spatial_next  = verdict.forward ? verdict.new_spatial  : cur_spatial_reg;
    assign cur_temporal_next = verdict.forward ? verdict.new_temporal : cur_temporal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spatial_count   <= 4'd1;
            cfg_reg.temporal_count  <= 4'd1;
            cfg_reg.target_spatial  <= 3'd0;
            cfg_reg.target_temporal <= 3'd0;
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            cur_spatial_reg         <= LAYER_NONE;
            cur_temporal_reg        <= LAYER_NONE;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (reg_index_t'(cfg_index))
                    REG_SPATIAL_COUNT:   cfg_reg.spatial_count   <= cfg_data;
                    REG_TEMPORAL_COUNT:  cfg_reg.temporal_count  <= cfg_data;
                    REG_TARGET_SPATIAL:  cfg_reg.target_spatial  <= cfg_data[2:0];
                    REG_TARGET_TEMPORAL: cfg_reg.target_temporal <= cfg_data[2:0];
                    default: ;
                endcase
            end

            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (advance) begin
                out_valid_reg    <= 1'b1;
                cur_spatial_reg  <= cur_spatial_next;
                cur_temporal_reg <= cur_temporal_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pkt_reg.spatial      <= s_pkt_spatial;
            in_pkt_reg.temporal     <= s_pkt_temporal;
            in_pkt_reg.key_frame    <= s_key_frame;
            in_pkt_reg.end_of_frame <= s_end_of_frame;
        end
        if (advance) begin
            out_forward_reg <= verdict.forward;
            out_marker_reg  <= verdict.set_marker;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_forward    = out_forward_reg;
    assign m_set_marker = out_marker_reg;

endmodule

FILE: rtl/svcf_checker.sv
`include "svc_layer_packet_filter_core_assert.svh"

module svcf_checker
    import svcf_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [1:0] cfg_index,
    input logic [3:0] cfg_data,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_forward,
    input logic       m_set_marker
);

    // shadow of the spatial count as seen on the config port
    logic [3:0] scount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scount_reg <= 4'd1;
        end else if (cfg_valid && cfg_ready &&
                     reg_index_t'(cfg_index) == REG_SPATIAL_COUNT) begin
            scount_reg <= cfg_data;
        end
    end

    `SVCF_ASSERT_IMP(a_marker_needs_fwd, aclk, aresetn, m_valid && !m_forward, !m_set_marker, "marker set on a dropped packet")
    `SVCF_ASSERT_IMP(a_zero_count_drops, aclk, aresetn, m_valid && scount_reg == 4'd0, !m_forward, "packet forwarded with spatial count zero")
    `SVCF_ASSERT_NXT(a_result_holds, aclk, m_valid && !m_ready, m_valid && $stable(m_forward) && $stable(m_set_marker), "stalled result changed", aresetn)
    `SVCF_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid, "result valid right after reset")

endmodule

bind svc_layer_packet_filter_core svcf_checker u_svcf_checker (.*);

FILE: tb/svc_layer_packet_filter_core_tb.sv
module svc_layer_packet_filter_core_tb;
    import svcf_pkg::*;

    // One expected result beat.
    typedef struct packed {
        logic forward;
        logic set_marker;
    } filter_verdict_t;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_AFTER     = 300;  // results seen before the long hold-off
    localparam int HOLD_CYCLES    = 250;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int QUIET_ITEMS    = 80;

    // ---------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_pkt_spatial = '0;
    logic [2:0] s_pkt_temporal = '0;
    logic       s_key_frame = 1'b0;
    logic       s_end_of_frame = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_forward;
    logic       m_set_marker;

    svc_layer_packet_filter_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pkt_spatial  (s_pkt_spatial),
        .s_pkt_temporal (s_pkt_temporal),
        .s_key_frame    (s_key_frame),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_forward      (m_forward),
        .m_set_marker   (m_set_marker)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow of the filter: config registers and current layers
    // ---------------------------------------------------------------
    logic [3:0] mir_spatial_count   = 4'd1;
    logic [3:0] mir_temporal_count  = 4'd1;
    logic [2:0] mir_target_spatial  = 3'd0;
    logic [2:0] mir_target_temporal = 3'd0;
    layer_t     cur_spatial  = LAYER_NONE;
    layer_t     cur_temporal = LAYER_NONE;

    pkt_t            pending_pkts[$];       // descriptors not yet offered
    filter_verdict_t expected_verdicts[$];  // verdicts of accepted beats, oldest first
    int              outstanding = 0;       // queued but not yet accepted
    int              errors = 0;
    int              results_seen = 0;
    int              cycle_count = 0;
    bit              quiet = 1'b0;          // no idling on either side

    // Counts above LAYER_MAX behave as LAYER_MAX.
    function automatic int layer_limit(input logic [3:0] cnt);
        return (int'(cnt) > LAYER_MAX) ? LAYER_MAX : int'(cnt);
    endfunction

    // Decide one descriptor against the shadow state; updates the current
    // layers only when the packet is forwarded.
    function automatic filter_verdict_t filter_decide(input pkt_t p);
        filter_verdict_t v;
        int ps, pt, cs, ct, ns, nt, ts, tt;
        v  = '0;
        ps = int'(p.spatial);
        pt = int'(p.temporal);
        cs = int'(cur_spatial);
        ct = int'(cur_temporal);
        ts = int'(mir_target_spatial);
        tt = int'(mir_target_temporal);
        ns = cs;
        nt = ct;
        // layer too high, also covers a zero count
        if (ps >= layer_limit(mir_spatial_count) || pt >= layer_limit(mir_temporal_count))
            return v;
        // spatial step: up on a key frame, down on end of frame at target;
        // either one restarts the temporal layer at zero
        if (ts > cs) begin
            if (p.key_frame) begin
                ns = ts;
                nt = 0;
            end
        end else if (ts < cs) begin
            if (ps == ts && p.end_of_frame) begin
                ns = ts;
                nt = 0;
            end
        end
        if (ps > ns)
            return v;
        // temporal step judged against the layer before the spatial step
        if (tt > ct) begin
            if (pt > ct)
                nt = pt;
        end else if (tt < ct) begin
            if (pt == tt && p.end_of_frame)
                nt = pt;
        end
        if (pt > nt)
            return v;
        v.forward    = 1'b1;
        v.set_marker = (ps == ns) && p.end_of_frame;
        cur_spatial  = layer_t'(ns);
        cur_temporal = layer_t'(nt);
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Input driver: offers queued descriptors, with random gaps of idle cycles
    // ---------------------------------------------------------------
    pkt_t beat_pkt = '0;
    int   gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                // beat taken: predict now, in acceptance order
                expected_verdicts.push_back(filter_decide(beat_pkt));
                outstanding--;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!quiet && pending_pkts.size() > 0 &&
                             $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else if (pending_pkts.size() > 0) begin
                    beat_pkt = pending_pkts.pop_front();
                    s_pkt_spatial  <= beat_pkt.spatial;
                    s_pkt_temporal <= beat_pkt.temporal;
                    s_key_frame    <= beat_pkt.key_frame;
                    s_end_of_frame <= beat_pkt.end_of_frame;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: checks each beat, random stalls, and one long
    // hold-off so the pipe fills and s_ready drops
    // ---------------------------------------------------------------
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        filter_verdict_t exp_v;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_verdicts.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected (forward %0b marker %0b)",
                             $time, m_forward, m_set_marker);
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if (m_forward !== exp_v.forward) begin
                        errors++;
                        $display("%0t: forward mismatch, expected %0b actual %0b",
                                 $time, exp_v.forward, m_forward);
                    end
                    if (m_set_marker !== exp_v.set_marker) begin
                        errors++;
                        $display("%0t: set_marker mismatch, expected %0b actual %0b",
                                 $time, exp_v.set_marker, m_set_marker);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequencing helpers; wait_drained and cfg_write return on the falling
    // edge so the caller never races the clocked driver and monitor
    // (cfg_write itself drives the config port from the rising edge)
    task automatic push_pkt(input int sp, input int tp, input bit key, input bit eof);
        pkt_t p;
        p.spatial      = 3'(sp);
        p.temporal     = 3'(tp);
        p.key_frame    = key;
        p.end_of_frame = eof;
        pending_pkts.push_back(p);
        outstanding++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (outstanding != 0 || expected_verdicts.size() != 0);
    endtask

    // Register write over the config channel; only called while idle.
    task automatic cfg_write(input reg_index_t idx, input logic [3:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SPATIAL_COUNT:   mir_spatial_count   = val;
            REG_TEMPORAL_COUNT:  mir_temporal_count  = val;
            REG_TARGET_SPATIAL:  mir_target_spatial  = val[2:0];
            REG_TARGET_TEMPORAL: mir_target_temporal = val[2:0];
        endcase
        @(negedge aclk);
    endtask

    function automatic logic [3:0] random_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 4'd0;
        if (r == 1)
            return 4'(LAYER_MAX + $urandom_range(1, 15 - LAYER_MAX));
        return 4'($urandom_range(1, LAYER_MAX));
    endfunction

    // Mostly in-range descriptors, often at the target layers, so the
    // layer state actually moves; the rest is unconstrained noise.
    function automatic pkt_t random_pkt();
        pkt_t p;
        int sc, tc;
        sc = layer_limit(mir_spatial_count);
        tc = layer_limit(mir_temporal_count);
        p.spatial  = 3'($urandom_range(0, 7));
        p.temporal = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 85) begin
            if (sc > 0)
                p.spatial = 3'($urandom_range(0, sc - 1));
            if (tc > 0)
                p.temporal = 3'($urandom_range(0, tc - 1));
            if ($urandom_range(0, 3) == 0)
                p.spatial = mir_target_spatial;
            if ($urandom_range(0, 3) == 0)
                p.temporal = mir_target_temporal;
        end
        p.key_frame    = ($urandom_range(0, 4) == 0);
        p.end_of_frame = ($urandom_range(0, 2) == 0);
        return p;
    endfunction

    task automatic random_config();
        cfg_write(REG_SPATIAL_COUNT, random_count());
        cfg_write(REG_TEMPORAL_COUNT, random_count());
        // bit 3 is dropped by the target registers; toggle it anyway
        cfg_write(REG_TARGET_SPATIAL, 4'($urandom_range(0, 15)));
        cfg_write(REG_TARGET_TEMPORAL, 4'($urandom_range(0, 15)));
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: one layer each, no layer yet
        push_pkt(0, 0, 0, 0);
        push_pkt(0, 0, 1, 1);
        push_pkt(7, 7, 1, 1);
        push_pkt(1, 0, 1, 0);
        wait_drained();

        // counts above the maximum, targets at the top
        cfg_write(REG_SPATIAL_COUNT, 4'd15);
        cfg_write(REG_TEMPORAL_COUNT, 4'd15);
        cfg_write(REG_TARGET_SPATIAL, 4'd7);
        cfg_write(REG_TARGET_TEMPORAL, 4'd7);
        push_pkt(7, 7, 0, 0);   // no key frame yet: stays below, dropped
        push_pkt(7, 7, 1, 1);   // key frame lifts spatial, temporal follows
        push_pkt(3, 5, 0, 1);
        push_pkt(0, 7, 0, 0);
        wait_drained();

        // step down: spatial on end of frame at target, temporal override
        cfg_write(REG_TARGET_SPATIAL, 4'd2);
        cfg_write(REG_TARGET_TEMPORAL, 4'd1);
        push_pkt(2, 0, 0, 0);
        push_pkt(2, 1, 0, 1);
        push_pkt(5, 0, 0, 0);   // above the new layer: dropped, state kept
        push_pkt(2, 3, 0, 0);
        push_pkt(2, 1, 0, 1);
        wait_drained();

        // zero counts drop everything
        cfg_write(REG_SPATIAL_COUNT, 4'd0);
        cfg_write(REG_TEMPORAL_COUNT, 4'd0);
        push_pkt(0, 0, 1, 1);
        wait_drained();

        // layer at the count is too high
        cfg_write(REG_SPATIAL_COUNT, 4'd3);
        cfg_write(REG_TEMPORAL_COUNT, 4'd8);
        push_pkt(3, 0, 1, 1);
        push_pkt(2, 7, 1, 1);
        push_pkt(0, 0, 0, 1);
        wait_drained();

        cfg_write(REG_SPATIAL_COUNT, 4'd1);
        cfg_write(REG_TEMPORAL_COUNT, 4'd0);
        push_pkt(0, 0, 1, 0);
        wait_drained();

        // random settings, layer state carried across phases
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_config();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pending_pkts.push_back(random_pkt());
                outstanding++;
            end
            wait_drained();
        end

        // last stretch at full rate
        quiet = 1'b1;
        cfg_write(REG_SPATIAL_COUNT, 4'd8);
        cfg_write(REG_TEMPORAL_COUNT, 4'd8);
        cfg_write(REG_TARGET_SPATIAL, 4'($urandom_range(0, 7)));
        cfg_write(REG_TARGET_TEMPORAL, 4'($urandom_range(0, 7)));
        for (int i = 0; i < QUIET_ITEMS; i++) begin
            pending_pkts.push_back(random_pkt());
            outstanding++;
        end
        wait_drained();
        repeat (10) @(negedge aclk);

        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
